// ===== rtl/tlpm_pkg.sv =====
// shared types and codes for the trie longest-prefix-match block
package tlpm_pkg;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   localparam logic [31:0] HASH_MULT = 32'd2654435761;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_NODE,
      ST_HASH,
      ST_PROBE,
      ST_CHECK,
      ST_FINISH,
      ST_QDATA,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] key;
   } hash_req_type;

endpackage

// ===== rtl/tlpm_ram.sv =====
// generic simple dual-port ram with registered read
module tlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/tlpm_hash.sv =====
// edge slot hash: multiplicative hash, the low product bits select the slot, registered
module tlpm_hash
   import tlpm_pkg::*;
#(
   parameter int SLOTS = 2048
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hash_req_type             req,
   output logic                     done,
   output logic [$clog2(SLOTS)-1:0] slot
);

   localparam int SW = $clog2(SLOTS);

   // slot count is a power of two, so only the low bits of the product matter
   logic [SW-1:0] prod;
   logic [SW-1:0] slot_ff, slot_in;
   logic          done_ff, done_in;

   always_comb begin
      prod    = req.key[SW-1:0] * HASH_MULT[SW-1:0];
      done_in = req.start;
      slot_in = slot_ff;
      if (req.start) begin
         slot_in = prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      slot_ff <= slot_in;
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

// ===== rtl/trie_longest_prefix_match.sv =====
// top level of the trie longest-prefix-match block
// a character holds the input through accept, node read, hash, read/check per probe, finish
// a character after a stopped query walk or a failed insert skips hash and probes: accept, node read, finish
// last character: a query reads the end node first; its word shows as the input frees
// one character in flight at a time; the edge probe loop sets the rate; edge slots power of two
// reset: walk to the root, node store to the root alone, edge store swept slot by slot
module trie_longest_prefix_match
   import tlpm_pkg::*;
#(
   parameter int MAX_NODES  = 1024,
   parameter int EDGE_SLOTS = 2048,
   parameter int MAX_PROBES = 8,
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // symbol[7:0], entry_value[23:8]
   input  logic        req_tuser,   // func
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // found[0], match_value[16:1], table_full[17], zero fill
   output logic        rsp_tuser    // kind
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int SW = $clog2(EDGE_SLOTS);
   localparam int PW = $clog2(MAX_PROBES + 1);
   localparam int EW = 1 + 8 + 2 * NW;      // valid, parent, symbol, child
   localparam int NDW = 1 + VALUE_BITS;     // has value, value

   state_type state_ff, state_in;

   // walk state
   logic [NW-1:0]         cur_ff, cur_in;
   logic                  stopped_ff, stopped_in;
   logic                  failed_ff, failed_in;
   logic                  best_found_ff, best_found_in;
   logic [VALUE_BITS-1:0] best_val_ff, best_val_in;
   logic [NW:0]           count_ff, count_in;

   // latched character
   logic                  func_ff, func_in;
   logic [7:0]            sym_ff, sym_in;
   logic                  last_ff, last_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;

   // probe loop
   logic [SW-1:0]         slot_ff, slot_in;
   logic [PW-1:0]         probe_ff, probe_in;
   logic [SW-1:0]         clr_ff, clr_in;

   // result word
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [15:0]           rsp_val_ff, rsp_val_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic                  res_found_ff, res_found_in;
   logic [VALUE_BITS-1:0] res_val_ff, res_val_in;

   // memories
   logic           edge_we;
   logic [SW-1:0]  edge_waddr, edge_raddr;
   logic [EW-1:0]  edge_wdata, edge_rdata;
   logic           node_we;
   logic [NW-1:0]  node_waddr, node_raddr;
   logic [NDW-1:0] node_wdata, node_rdata;

   hash_req_type   hreq;
   logic           hdone;
   logic [SW-1:0]  hslot;

   // edge slot fields
   logic           e_valid;
   logic [NW-1:0]  e_parent, e_child;
   logic [7:0]     e_sym;
   assign {e_valid, e_parent, e_sym, e_child} = edge_rdata;

   tlpm_ram #(.WIDTH(EW), .DEPTH(EDGE_SLOTS)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   tlpm_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (node_waddr),
      .wdata (node_wdata),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   tlpm_hash #(.SLOTS(EDGE_SLOTS)) u_hash (
      .clock (clock),
      .reset (reset),
      .req   (hreq),
      .done  (hdone),
      .slot  (hslot)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {6'd0, rsp_full_ff, rsp_val_ff, rsp_found_ff};

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      stopped_in    = stopped_ff;
      failed_in     = failed_ff;
      best_found_in = best_found_ff;
      best_val_in   = best_val_ff;
      count_in      = count_ff;
      func_in       = func_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      val_in        = val_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_full_in   = rsp_full_ff;
      res_found_in  = res_found_ff;
      res_val_in    = res_val_ff;
      edge_we       = 1'b0;
      edge_waddr    = slot_ff;
      edge_wdata    = {1'b1, cur_ff, sym_ff, count_ff[NW-1:0]};
      edge_raddr    = slot_ff;
      node_we       = 1'b0;
      node_waddr    = cur_ff;
      node_wdata    = {1'b1, val_ff};
      node_raddr    = cur_ff;
      hreq.start    = 1'b0;
      hreq.key      = 32'({cur_ff, sym_ff});

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // sweep the edge store, keep the root unvalued
            edge_we    = 1'b1;
            edge_waddr = clr_ff;
            edge_wdata = '0;
            node_we    = 1'b1;
            node_waddr = '0;
            node_wdata = '0;
            clr_in     = clr_ff + SW'(1);
            if (clr_ff == SW'(EDGE_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               sym_in   = req_tdata[7:0];
               last_in  = req_tlast;
               val_in   = VALUE_BITS'(req_tdata[23:8]);
               state_in = ST_NODE;
            end
         end
         ST_NODE: begin
            // node data of the current node is here now
            if (func_ff == FUNC_QUERY && !stopped_ff && node_rdata[NDW-1]) begin
               best_found_in = 1'b1;
               best_val_in   = node_rdata[VALUE_BITS-1:0];
            end
            if ((func_ff == FUNC_INSERT && failed_ff) ||
                (func_ff == FUNC_QUERY && stopped_ff)) begin
               state_in = ST_FINISH;
            end else begin
               hreq.start = 1'b1;
               state_in   = ST_HASH;
            end
         end
         ST_HASH: begin
            probe_in = '0;
            if (hdone) begin
               slot_in  = hslot;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // edge read issued at slot_ff
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_FINISH;
            if (!e_valid) begin
               // free slot: edge is missing
               if (func_ff == FUNC_QUERY) begin
                  stopped_in = 1'b1;
               end else if (count_ff < (NW+1)'(MAX_NODES)) begin
                  edge_we    = 1'b1;
                  node_we    = 1'b1;
                  node_waddr = count_ff[NW-1:0];
                  node_wdata = '0;
                  cur_in     = count_ff[NW-1:0];
                  count_in   = count_ff + (NW+1)'(1);
               end else begin
                  failed_in = 1'b1;
               end
            end else if (e_parent == cur_ff && e_sym == sym_ff) begin
               cur_in = e_child;
            end else if (probe_ff == PW'(MAX_PROBES - 1)) begin
               if (func_ff == FUNC_QUERY) begin
                  stopped_in = 1'b1;
               end else begin
                  failed_in = 1'b1;
               end
            end else begin
               probe_in = probe_ff + PW'(1);
               slot_in  = (slot_ff == SW'(EDGE_SLOTS - 1)) ? '0 : slot_ff + SW'(1);
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (func_ff == FUNC_INSERT) begin
               node_we      = !failed_ff;
               res_found_in = 1'b0;
               res_val_in   = '0;
               state_in     = ST_OUT;
            end else begin
               // node_raddr is cur_ff: fetch the end node
               state_in = ST_QDATA;
            end
         end
         ST_QDATA: begin
            if (node_rdata[NDW-1]) begin
               res_found_in = 1'b1;
               res_val_in   = node_rdata[VALUE_BITS-1:0];
            end else begin
               res_found_in = best_found_ff;
               res_val_in   = best_found_ff ? best_val_ff : '0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = (func_ff == FUNC_QUERY) ? KIND_QUERY : KIND_INSERT;
               rsp_found_in  = res_found_ff;
               rsp_val_in    = 16'(res_val_ff);
               rsp_full_in   = (func_ff == FUNC_INSERT) && failed_ff;
               // key done: walk back to the root
               cur_in        = '0;
               stopped_in    = 1'b0;
               failed_in     = 1'b0;
               best_found_in = 1'b0;
               best_val_in   = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cur_ff        <= '0;
         stopped_ff    <= 1'b0;
         failed_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         count_ff      <= (NW+1)'(1);
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         stopped_ff    <= stopped_in;
         failed_ff     <= failed_in;
         best_found_ff <= best_found_in;
         count_ff      <= count_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      best_val_ff  <= best_val_in;
      func_ff      <= func_in;
      sym_ff       <= sym_in;
      last_ff      <= last_in;
      val_ff       <= val_in;
      slot_ff      <= slot_in;
      probe_ff     <= probe_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_found_ff <= rsp_found_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_full_ff  <= rsp_full_in;
      res_found_ff <= res_found_in;
      res_val_ff   <= res_val_in;
   end

`ifndef ASSERT_OFF
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("input accepted during store clearing");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (NW+1)'(MAX_NODES))
      else $error("node count beyond store size");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (probe_ff < PW'(MAX_PROBES)))
      else $error("probe count beyond limit");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) |=> rsp_tvalid)
      else $error("result word not presented");
`endif

endmodule
